[rtl/core/multiboot2_header_scanner_unit_macros.svh]
// Assertion helpers for the header scanner. Both forms report through $error.
`ifndef MULTIBOOT2_HEADER_SCANNER_UNIT_MACROS_SVH
`define MULTIBOOT2_HEADER_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define MB2HS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mb2hs: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define MB2HS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mb2hs: next-cycle check failed");
`else
`define MB2HS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MB2HS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/mb2hs_pkg.sv]
`default_nettype none

package mb2hs_pkg;

  localparam int unsigned MB2HS_SEARCH_WINDOW = 32768;

  localparam logic [31:0] MB2HS_MAGIC       = 32'he85250d6;
  localparam logic [31:0] MB2HS_MIN_HDR_LEN = 32'd16;
  localparam logic [31:0] MB2HS_MIN_TAG_LEN = 32'd8;
  localparam logic [32:0] MB2HS_TAG_ALIGN_M = 33'd7;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_ARCH  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CSUM  = 3'd4,
    ST_BAD_TAG   = 3'd5
  } status_t;

  typedef enum logic [5:0] {
    PH_SEARCH  = 6'b000001,
    PH_ARCH    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_SUM     = 6'b001000,
    PH_TAGTYPE = 6'b010000,
    PH_TAGSIZE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } mb2hs_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] header_offset;
  } mb2hs_out_t;

  typedef struct packed {
    logic [29:0] word_index;
    phase_t      phase;
    logic [31:0] header_length;
    logic [31:0] field_sum;
    logic [32:0] tag_pos;
    logic [15:0] tag_type;
    logic        decided;
  } mb2hs_state_t;

  localparam mb2hs_state_t MB2HS_STATE_RST = '{
    word_index:    30'd0,
    phase:         PH_SEARCH,
    header_length: 32'd0,
    field_sum:     32'd0,
    tag_pos:       33'd0,
    tag_type:      16'd0,
    decided:       1'b0
  };

endpackage

`default_nettype wire

[rtl/core/mb2hs_step.sv]
`default_nettype none

// Next-state and result logic for one image word.
module mb2hs_step
  import mb2hs_pkg::*;
#(
  parameter int unsigned SEARCH_WINDOW = MB2HS_SEARCH_WINDOW,
  localparam int OFFS_W = $clog2(SEARCH_WINDOW)
) (
  input  wire mb2hs_state_t      st,
  input  wire logic [OFFS_W-1:0] cand,
  input  wire mb2hs_in_t         din,
  input  wire logic [31:0]       image_size,
  output mb2hs_state_t           st_nxt,
  output logic [OFFS_W-1:0]      cand_nxt,
  output logic                   emit,
  output mb2hs_out_t             res
);

  localparam logic [31:0] WinLimit = 32'(SEARCH_WINDOW);

  logic [31:0] pos;
  logic [31:0] limit;
  logic [31:0] cand_ext;
  logic [31:0] sum_new;
  logic [32:0] tag_round;
  logic [32:0] tag_pos_new;
  logic        emit_sw;
  status_t     status;

  always_comb begin
    st_nxt      = st;
    cand_nxt    = cand;
    emit_sw     = 1'b0;
    status      = ST_OK;
    pos         = {st.word_index, 2'b00};
    limit       = (image_size < WinLimit) ? image_size : WinLimit;
    cand_ext    = 32'(cand);
    sum_new     = st.field_sum + din.word;
    tag_round   = ({1'b0, din.word} + MB2HS_TAG_ALIGN_M) & ~MB2HS_TAG_ALIGN_M;
    tag_pos_new = st.tag_pos + tag_round;

    if (!st.decided) begin
      case (st.phase)
        PH_SEARCH: begin
          if (!st.word_index[0]) begin
            if (({1'b0, pos} + 33'd16) > {1'b0, limit}) begin
              emit_sw = 1'b1;
              status  = ST_NOT_FOUND;
            end else if (din.word == MB2HS_MAGIC) begin
              cand_nxt         = pos[OFFS_W-1:0];
              st_nxt.field_sum = din.word;
              st_nxt.phase     = PH_ARCH;
            end
          end
        end
        PH_ARCH: begin
          if (din.word != 32'd0) begin
            emit_sw = 1'b1;
            status  = ST_BAD_ARCH;
          end else begin
            st_nxt.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (din.word < MB2HS_MIN_HDR_LEN ||
              ({1'b0, cand_ext} + {1'b0, din.word}) > {1'b0, image_size}) begin
            emit_sw = 1'b1;
            status  = ST_BAD_LEN;
          end else begin
            st_nxt.header_length = din.word;
            st_nxt.field_sum     = sum_new;
            st_nxt.phase         = PH_SUM;
          end
        end
        PH_SUM: begin
          st_nxt.field_sum = sum_new;
          if (sum_new != 32'd0) begin
            emit_sw = 1'b1;
            status  = ST_BAD_CSUM;
          end else begin
            st_nxt.tag_pos = 33'd16;
            if (33'd16 >= {1'b0, st.header_length}) begin
              emit_sw = 1'b1;
              status  = ST_OK;
            end else begin
              st_nxt.phase = PH_TAGTYPE;
            end
          end
        end
        PH_TAGTYPE: begin
          if ({2'b00, pos} == ({2'b00, cand_ext} + {1'b0, st.tag_pos})) begin
            st_nxt.tag_type = din.word[15:0];
            st_nxt.phase    = PH_TAGSIZE;
          end
        end
        PH_TAGSIZE: begin
          if (din.word < MB2HS_MIN_TAG_LEN ||
              ({1'b0, st.tag_pos} + 34'(din.word)) > {2'b00, st.header_length}) begin
            emit_sw = 1'b1;
            status  = ST_BAD_TAG;
          end else if (st.tag_type == 16'd0) begin
            emit_sw = 1'b1;
            status  = ST_OK;
          end else begin
            st_nxt.tag_pos = tag_pos_new;
            if (tag_pos_new >= {1'b0, st.header_length}) begin
              emit_sw = 1'b1;
              status  = ST_OK;
            end else begin
              st_nxt.phase = PH_TAGTYPE;
            end
          end
        end
        default: begin
          st_nxt.phase = PH_SEARCH;
        end
      endcase
    end

    st_nxt.decided    = st.decided | emit_sw;
    st_nxt.word_index = st.word_index + 30'd1;
    emit              = emit_sw;

    // The last word closes the image; an undecided image gets a verdict now.
    if (din.last) begin
      if (!st.decided && !emit_sw) begin
        emit   = 1'b1;
        status = (st_nxt.phase == PH_SEARCH) ? ST_NOT_FOUND : ST_BAD_LEN;
      end
      st_nxt   = MB2HS_STATE_RST;
      cand_nxt = '0;
    end

    res.status        = status;
    res.header_offset = (status == ST_OK) ? cand_ext[14:0] : 15'd0;
  end

endmodule

`default_nettype wire

[rtl/core/multiboot2_header_scanner_unit.sv]
`default_nettype none

// Channel  Dir  Payload       Handshake
// in_      in   mb2hs_in_t    in_valid / in_ready
// out_     out  mb2hs_out_t   out_valid / out_ready
// cfg_     in   32-bit size   cfg_we, no wait
//
// One image word is taken per cycle while input is not stalled by a waiting result;
// the sustained rate is one beat per clock, set by the combinational scan-state update in mb2hs_step.
// A deciding beat passes the input register and then the result register before its result is on out_.
// rst_n is synchronous and active low; it clears the scan state and image_size.
// A waiting result stalls input only when the held beat yields a result too;
// beats that decide nothing keep flowing past a stalled output.

`include "multiboot2_header_scanner_unit_macros.svh"

module multiboot2_header_scanner_unit
  import mb2hs_pkg::*;
#(
  parameter int unsigned SEARCH_WINDOW = MB2HS_SEARCH_WINDOW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mb2hs_in_t   in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mb2hs_out_t       out_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int OFFS_W = $clog2(SEARCH_WINDOW);

  // Input register: the beat that the step logic works on.
  mb2hs_in_t         in_data_r;
  logic              in_vld_r;

  // Scan state and the offset of the candidate header.
  mb2hs_state_t      st_r;
  mb2hs_state_t      st_nxt;
  logic [OFFS_W-1:0] cand_r;
  logic [OFFS_W-1:0] cand_nxt;

  logic [31:0]       image_size_r;

  // Result register.
  mb2hs_out_t        out_r;
  logic              out_vld_r;

  logic              emit;
  mb2hs_out_t        res;
  logic              fire;

  mb2hs_step #(
    .SEARCH_WINDOW (SEARCH_WINDOW)
  ) u_step (
    .st         (st_r),
    .cand       (cand_r),
    .din        (in_data_r),
    .image_size (image_size_r),
    .st_nxt     (st_nxt),
    .cand_nxt   (cand_nxt),
    .emit       (emit),
    .res        (res)
  );

  // The held beat is consumed unless it yields a result while the result
  // register is full and not being drained.
  assign fire     = in_vld_r && (!out_vld_r || out_ready || !emit);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MB2HS_STATE_RST;
      cand_r <= '0;
    end else if (fire) begin
      st_r   <= st_nxt;
      cand_r <= cand_nxt;
    end
  end

  // The size register survives the clear done by the last word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= 32'd0;
    end else if (cfg_we) begin
      image_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A header always sits on an 8-byte boundary.
  `MB2HS_ASSERT_IMP(a_offset_aligned, clk, rst_n, out_vld_r, out_r.header_offset[2:0] == 3'd0)
  // Only a good header carries an offset.
  `MB2HS_ASSERT_IMP(a_offset_only_ok, clk, rst_n, out_vld_r && out_r.status != ST_OK, out_r.header_offset == 15'd0)
  `MB2HS_ASSERT_IMP(a_status_range, clk, rst_n, out_vld_r, out_r.status <= ST_BAD_TAG)
  // The last word returns the scanner to the start of a new image.
  `MB2HS_ASSERT_NXT(a_last_clears, clk, rst_n, fire && in_data_r.last, st_r == MB2HS_STATE_RST)
  // Once decided, the image stays decided until its last word.
  `MB2HS_ASSERT_NXT(a_decided_holds, clk, rst_n, st_r.decided && !(fire && in_data_r.last), st_r.decided)

endmodule

`default_nettype wire
